FILE: sv/rdiv_pkg.sv
// Shared types for the pipelined restoring divider.
package rdiv_pkg;

    // Control that travels beside the payload of every pipeline stage.
    typedef struct packed {
        logic valid;
        logic dbz;
    } stg_ctl_t;

endpackage

FILE: sv/rdiv_stage.sv
// One registered shift-compare-subtract step of the restoring divider.
module rdiv_stage
    import rdiv_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stg_ctl_t         in_ctl,
    input  logic [WIDTH-1:0] in_part,
    input  logic [WIDTH-1:0] in_quo,
    input  logic [WIDTH-1:0] in_dvs,
    output logic             in_ready,
    output stg_ctl_t         out_ctl,
    output logic [WIDTH-1:0] out_part,
    output logic [WIDTH-1:0] out_quo,
    output logic [WIDTH-1:0] out_dvs,
    input  logic             out_ready
);

    stg_ctl_t         ctl_reg;
    logic [WIDTH-1:0] part_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;

    logic [WIDTH-1:0] part_next;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;

    // The stage takes a new request when it is empty or its content moves on.
    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb
    begin
        shifted = {in_part, in_quo[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, in_dvs};
        if (diff[WIDTH+1])
        begin
            part_next = shifted[WIDTH-1:0];
            quo_next  = {in_quo[WIDTH-2:0], 1'b0};
        end
        else
        begin
            part_next = diff[WIDTH-1:0];
            quo_next  = {in_quo[WIDTH-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            part_reg <= part_next;
            quo_reg  <= quo_next;
            dvs_reg  <= in_dvs;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_part = part_reg;
    assign out_quo  = quo_reg;
    assign out_dvs  = dvs_reg;

endmodule

FILE: sv/restoring_divider_core.sv
// Top level of the pipelined unsigned restoring divider.
//
// This block divides an unsigned WIDTH-bit dividend by an unsigned WIDTH-bit
// divisor and returns the quotient and the remainder. It is a pipeline of
// WIDTH registered stages, one per quotient bit, each doing one shift,
// compare and conditional subtract of the partial remainder. A request can
// enter in every cycle while the output side does not stall, so the
// sustained rate is one division per cycle, and each result passes through
// the WIDTH stage registers in order. Each stage holds its request while the
// stage after it is full and stalled, and an empty stage always takes a new
// one, so bubbles close up and nothing is lost or repeated. A divisor of
// zero sets the divide_by_zero flag in tuser and forces quotient and
// remainder to zero.
module restoring_divider_core
    import rdiv_pkg::*;
#(
    parameter  int WIDTH  = 8,
    localparam int IN_W   = ((2 * WIDTH + 7) / 8) * 8,
    localparam int OUT_W  = ((2 * WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // dividend, divisor, zero fill
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // quotient, remainder, zero fill
    output logic             m_axis_tuser    // divide_by_zero
);

    stg_ctl_t         ctl   [WIDTH+1];
    logic [WIDTH-1:0] part  [WIDTH+1];
    logic [WIDTH-1:0] quo   [WIDTH+1];
    logic [WIDTH-1:0] dvs   [WIDTH+1];
    logic             rdy   [WIDTH+1];

    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;

    assign dividend = s_axis_tdata[WIDTH-1:0];
    assign divisor  = s_axis_tdata[2*WIDTH-1:WIDTH];

    // The first stage starts from a zero partial remainder with the dividend
    // in the quotient register; its bits shift out as quotient bits shift in.
    assign ctl[0].valid = s_axis_tvalid;
    assign ctl[0].dbz   = (divisor == '0);
    assign part[0]      = '0;
    assign quo[0]       = dividend;
    assign dvs[0]       = divisor;
    assign s_axis_tready = rdy[0];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_stage
        rdiv_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_ctl    (ctl[i]),
            .in_part   (part[i]),
            .in_quo    (quo[i]),
            .in_dvs    (dvs[i]),
            .in_ready  (rdy[i]),
            .out_ctl   (ctl[i+1]),
            .out_part  (part[i+1]),
            .out_quo   (quo[i+1]),
            .out_dvs   (dvs[i+1]),
            .out_ready (rdy[i+1])
        );
    end

    assign rdy[WIDTH] = m_axis_tready;

    // The last stage register is the output register. A zero divisor has
    // run through the array like any other value, so its result is masked.
    assign quotient  = ctl[WIDTH].dbz ? '0 : quo[WIDTH];
    assign remainder = ctl[WIDTH].dbz ? '0 : part[WIDTH];

    assign m_axis_tvalid = ctl[WIDTH].valid;
    assign m_axis_tuser  = ctl[WIDTH].dbz;
    assign m_axis_tdata  = OUT_W'({remainder, quotient});

`ifndef SYNTHESIS
    // A flagged division must come out with zero quotient and remainder.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (quotient == '0 && remainder == '0))
    else $error("divide by zero result is not cleared");

    // The remainder of a real division is always below its divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (remainder < dvs[WIDTH]))
    else $error("remainder not below divisor");

    // When the output side takes results, every stage moves and input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");
`endif

endmodule
